/* rtl/bhpq_pkg.sv */
// Shared types and constants for the binary heap priority queue.
`default_nettype none
package bhpq_pkg;
    localparam int HEAP_DEPTH_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [0:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_POP_RD_LAST,
        ST_POP_WR_ROOT,
        ST_DN_RD_L,
        ST_DN_RD_R,
        ST_DN_CMP,
        ST_DN_WR,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_DONE
    } exec_state_t;

    // Order test on two's complement values: strict.
    function automatic logic precedes(input logic [63:0] a, input logic [63:0] b,
                                      input logic max_first);
        logic lt;
        lt = $signed(a) < $signed(b);
        precedes = max_first ? ($signed(a) > $signed(b)) : lt;
    endfunction
endpackage
`default_nettype wire

/* rtl/bhpq_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* rtl/bhpq_front.sv */
// Request front end: accepts requests and queues them for the executor.
`default_nettype none
module bhpq_front #(
    parameter int VALUE_WIDTH = bhpq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   req_type,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        q_valid,
    output logic                        q_req,
    output logic      [VALUE_WIDTH-1:0] q_value,
    input  wire logic                   q_take
);
    // Two-entry queue.
    logic [1:0]             cnt_reg;
    logic                   rd_reg, wr_reg;
    logic                   req_mem [2];
    logic [VALUE_WIDTH-1:0] val_mem [2];
    logic                   push;

    assign busy    = cnt_reg == 2'd2;
    assign push    = start && !busy;
    assign q_valid = cnt_reg != 2'd0;
    assign q_req   = req_mem[rd_reg];
    assign q_value = val_mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_take)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            req_mem[wr_reg] <= req_type;
            val_mem[wr_reg] <= value;
        end
    end
endmodule
`default_nettype wire

/* rtl/bhpq_exec.sv */
// Heap executor: sift-up and sift-down over the heap RAM, one access a cycle.
`default_nettype none
module bhpq_exec #(
    parameter int HEAP_DEPTH  = bhpq_pkg::HEAP_DEPTH_DEF,
    parameter int VALUE_WIDTH = bhpq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   max_first,
    input  wire logic                   q_valid,
    input  wire logic                   q_req,
    input  wire logic [VALUE_WIDTH-1:0] q_value,
    output logic                        q_take,
    output logic                        idle,
    output logic                        done,
    output logic      [VALUE_WIDTH-1:0] top_val,
    output logic      [$clog2(HEAP_DEPTH+1)-1:0] count,
    output logic                        err
);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    bhpq_pkg::exec_state_t state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW:0]            child_reg, child_next;
    logic [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [VALUE_WIDTH-1:0] oth_reg, oth_next;
    logic [VALUE_WIDTH-1:0] top_reg, top_next;
    logic                   err_reg, err_next;

    logic                   we;
    logic [AW-1:0]          addr;
    logic [VALUE_WIDTH-1:0] wdata, rdata;
    logic [CW-1:0]          parent;
    logic [CW:0]            lchild;
    logic                   rd_prec_oth;

    bhpq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(HEAP_DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign parent = (pos_reg - CW'(1)) >> 1;
    assign lchild = {pos_reg, 1'b1};
    assign rd_prec_oth = bhpq_pkg::precedes(64'($signed(rdata)), 64'($signed(oth_reg)),
                                            max_first);

    assign idle    = state_reg == bhpq_pkg::ST_IDLE;
    assign done    = state_reg == bhpq_pkg::ST_DONE;
    assign top_val = top_reg;
    assign count   = count_reg;
    assign err     = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhpq_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        child_reg <= child_next;
        cur_reg   <= cur_next;
        oth_reg   <= oth_next;
        top_reg   <= top_next;
        err_reg   <= err_next;
    end

    // cur holds the moving entry; it is written to RAM only at its final slot.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        child_next = child_reg;
        cur_next   = cur_reg;
        oth_next   = oth_reg;
        top_next   = top_reg;
        err_next   = err_reg;
        q_take     = 1'b0;
        we         = 1'b0;
        addr       = '0;
        wdata      = cur_reg;
        unique case (state_reg)
            bhpq_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take   = 1'b1;
                    err_next = 1'b0;
                    cur_next = q_value;
                    if (q_req == bhpq_pkg::REQ_PUSH)
                    begin
                        if (count_reg == CW'(HEAP_DEPTH))
                        begin
                            err_next   = 1'b1;
                            state_next = bhpq_pkg::ST_TOP_RD;
                        end
                        else
                        begin
                            pos_next   = count_reg;
                            count_next = count_reg + CW'(1);
                            state_next = bhpq_pkg::ST_PUSH_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = bhpq_pkg::ST_TOP_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = bhpq_pkg::ST_POP_RD_LAST;
                    end
                end
            end
            bhpq_pkg::ST_PUSH_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    addr       = '0;
                    state_next = bhpq_pkg::ST_TOP_RD;
                end
                else
                begin
                    addr       = parent[AW-1:0];
                    state_next = bhpq_pkg::ST_PUSH_CMP;
                end
            end
            bhpq_pkg::ST_PUSH_CMP:
            begin
                // rdata is the parent entry
                if (bhpq_pkg::precedes(64'($signed(cur_reg)), 64'($signed(rdata)), max_first))
                begin
                    we         = 1'b1;
                    addr       = pos_reg[AW-1:0];
                    wdata      = rdata;
                    pos_next   = parent;
                    state_next = bhpq_pkg::ST_PUSH_RD;
                end
                else
                begin
                    we         = 1'b1;
                    addr       = pos_reg[AW-1:0];
                    state_next = bhpq_pkg::ST_TOP_RD;
                end
            end
            bhpq_pkg::ST_POP_RD_LAST:
            begin
                addr       = count_reg[AW-1:0];
                state_next = bhpq_pkg::ST_POP_WR_ROOT;
            end
            bhpq_pkg::ST_POP_WR_ROOT:
            begin
                cur_next   = rdata;
                pos_next   = '0;
                state_next = (count_reg == '0) ? bhpq_pkg::ST_TOP_RD
                                                : bhpq_pkg::ST_DN_RD_L;
            end
            bhpq_pkg::ST_DN_RD_L:
            begin
                if (lchild < {1'b0, count_reg})
                begin
                    addr       = lchild[AW-1:0];
                    child_next = lchild;
                    state_next = bhpq_pkg::ST_DN_RD_R;
                end
                else
                begin
                    we         = 1'b1;
                    addr       = pos_reg[AW-1:0];
                    state_next = bhpq_pkg::ST_TOP_RD;
                end
            end
            bhpq_pkg::ST_DN_RD_R:
            begin
                oth_next = rdata;
                if (child_reg + 1'b1 < {1'b0, count_reg})
                begin
                    addr       = AW'(child_reg + 1'b1);
                    state_next = bhpq_pkg::ST_DN_CMP;
                end
                else
                begin
                    state_next = bhpq_pkg::ST_DN_WR;
                end
            end
            bhpq_pkg::ST_DN_CMP:
            begin
                // right child wins only if strictly better
                if (rd_prec_oth)
                begin
                    oth_next   = rdata;
                    child_next = child_reg + 1'b1;
                end
                state_next = bhpq_pkg::ST_DN_WR;
            end
            bhpq_pkg::ST_DN_WR:
            begin
                if (bhpq_pkg::precedes(64'($signed(oth_reg)), 64'($signed(cur_reg)), max_first))
                begin
                    we         = 1'b1;
                    addr       = pos_reg[AW-1:0];
                    wdata      = oth_reg;
                    pos_next   = child_reg[CW-1:0];
                    state_next = bhpq_pkg::ST_DN_RD_L;
                end
                else
                begin
                    we         = 1'b1;
                    addr       = pos_reg[AW-1:0];
                    state_next = bhpq_pkg::ST_TOP_RD;
                end
            end
            bhpq_pkg::ST_TOP_RD:
            begin
                addr       = '0;
                state_next = bhpq_pkg::ST_TOP_WAIT;
            end
            bhpq_pkg::ST_TOP_WAIT:
            begin
                top_next   = (count_reg == '0) ? '0 : rdata;
                state_next = bhpq_pkg::ST_DONE;
            end
            bhpq_pkg::ST_DONE:
            begin
                state_next = bhpq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bhpq_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/binary_heap_priority_queue.sv */
// Top level of the binary heap priority queue.
// Each request is run by the executor, which walks the single-port heap RAM one
// access per cycle; a push sifts up and a pop sifts down over at most
// log2(HEAP_DEPTH) levels. A two-beat request queue lets start be taken while
// the executor works; busy is high only when that queue is full. Each result
// shows for one cycle with result_valid and cannot be held off. The user must
// write max_first only when idle; the block itself does not enforce it.
`default_nettype none
module binary_heap_priority_queue #(
    parameter int HEAP_DEPTH  = bhpq_pkg::HEAP_DEPTH_DEF,
    parameter int VALUE_WIDTH = bhpq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   req_type,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_data,
    output logic                        result_valid,
    output logic      [VALUE_WIDTH-1:0] top_value,
    output logic      [$clog2(HEAP_DEPTH+1)-1:0] entry_count,
    output logic                        is_empty,
    output logic                        error
);
    logic                   max_first_reg;
    logic                   q_valid, q_req, q_take, idle, done, err;
    logic [VALUE_WIDTH-1:0] q_value, top_val;
    logic [$clog2(HEAP_DEPTH+1)-1:0] count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_first_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_first_reg <= cfg_data;
        end
    end

    bhpq_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .value(value),
        .q_valid(q_valid), .q_req(q_req), .q_value(q_value), .q_take(q_take)
    );

    bhpq_exec #(.HEAP_DEPTH(HEAP_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_exec (
        .clk(clk), .rst_n(rst_n), .max_first(max_first_reg),
        .q_valid(q_valid), .q_req(q_req), .q_value(q_value), .q_take(q_take),
        .idle(idle), .done(done), .top_val(top_val), .count(count), .err(err)
    );

    assign result_valid = done;
    assign top_value    = top_val;
    assign entry_count  = count;
    assign is_empty     = count == '0;
    assign error        = err;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count <= ($clog2(HEAP_DEPTH+1))'(HEAP_DEPTH))
        else $error("entry count past depth");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> idle && q_valid)
        else $error("queue read outside idle");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_empty |-> top_value == '0)
        else $error("nonzero top on empty heap");
endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the binary heap priority queue: predicted heap vs DUT results.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        req_type = 1'b0;
    logic [31:0] value = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        result_valid;
    logic [31:0] top_value;
    logic [6:0]  entry_count;
    logic        is_empty;
    logic        error;

    typedef struct packed {
        logic [31:0] top;
        logic [6:0]  cnt;
        logic        empty;
        logic        err;
    } heap_status_t;

    // predicted heap contents and order mode
    logic signed [31:0] heap_model [DEPTH];
    int                 heap_size;
    logic               model_max_first;
    heap_status_t       expected_status [$];

    int  fail_count;
    int  quiet_cycles = 0;
    bit  idle_enable;

    binary_heap_priority_queue u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .top_value(top_value),
        .entry_count(entry_count), .is_empty(is_empty), .error(error)
    );

    always #1 clk = ~clk;

    function automatic bit ahead(logic signed [31:0] a, logic signed [31:0] b);
        return model_max_first ? (a > b) : (a < b);
    endfunction

    function automatic void swap_slots(int i, int j);
        logic signed [31:0] t;
        t = heap_model[i];
        heap_model[i] = heap_model[j];
        heap_model[j] = t;
    endfunction

    function automatic heap_status_t predict_request(bhpq_pkg::req_t kind, logic [31:0] val);
        heap_status_t s;
        int           pos;
        int           c;
        s.err = 1'b0;
        if (kind == bhpq_pkg::REQ_PUSH) begin
            if (heap_size >= DEPTH) begin
                s.err = 1'b1;
            end
            else begin
                heap_model[heap_size] = val;
                pos = heap_size;
                heap_size++;
                while (pos > 0 && ahead(heap_model[pos], heap_model[(pos - 1) / 2])) begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
        end
        else begin
            if (heap_size == 0) begin
                s.err = 1'b1;
            end
            else begin
                swap_slots(0, heap_size - 1);
                heap_size--;
                pos = 0;
                while (2 * pos + 1 < heap_size) begin
                    c = 2 * pos + 1;
                    if (c + 1 < heap_size && ahead(heap_model[c + 1], heap_model[c]))
                        c++;
                    if (!ahead(heap_model[c], heap_model[pos]))
                        break;
                    swap_slots(c, pos);
                    pos = c;
                end
            end
        end
        s.top   = heap_size != 0 ? heap_model[0] : 32'd0;
        s.cnt   = 7'(heap_size);
        s.empty = heap_size == 0;
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // result checker; results cannot be stalled
    always @(posedge clk) begin
        heap_status_t e;
        if (rst_n && result_valid) begin
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected result", top_value, 32'd0);
            end
            else begin
                e = expected_status.pop_front();
                if (top_value !== e.top)
                    report_mismatch("top_value", top_value, e.top);
                if (entry_count !== e.cnt)
                    report_mismatch("entry_count", 32'(entry_count), 32'(e.cnt));
                if (is_empty !== e.empty)
                    report_mismatch("is_empty", 32'(is_empty), 32'(e.empty));
                if (error !== e.err)
                    report_mismatch("error", 32'(error), 32'(e.err));
            end
        end
    end

    // watchdog on cycles without any result or accepted beat
    always @(posedge clk) begin
        if (!rst_n || result_valid || (start && !busy) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // start stays high between back-to-back beats; a gap drops it first
    task automatic random_gap();
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_request(bhpq_pkg::req_t kind, logic [31:0] val);
        random_gap();
        start    <= 1'b1;
        req_type <= kind;
        value    <= val;
        do @(posedge clk); while (busy);
        expected_status.insert(expected_status.size(), predict_request(kind, val));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
    endtask

    task automatic write_mode(logic mode);
        wait_drained();
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        model_max_first = mode;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edge_vals [6];
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h5, 32'h5};
        send_request(bhpq_pkg::REQ_POP, 32'hffff_ffff);    // pop on empty heap
        foreach (edge_vals[i]) send_request(bhpq_pkg::REQ_PUSH, edge_vals[i]);
        repeat (7) send_request(bhpq_pkg::REQ_POP, 32'h0);
    endtask

    task automatic test_fill_and_overflow(logic mode);
        write_mode(mode);
        repeat (DEPTH) send_request(bhpq_pkg::REQ_PUSH, pick_value());
        send_request(bhpq_pkg::REQ_PUSH, 32'h1234_5678);  // push on full heap
        repeat (DEPTH + 1) send_request(bhpq_pkg::REQ_POP, $urandom);
    endtask

    task automatic test_random(int n, int push_bias);
        repeat (n) begin
            if ($urandom_range(0, 99) < push_bias)
                send_request(bhpq_pkg::REQ_PUSH, pick_value());
            else
                send_request(bhpq_pkg::REQ_POP, $urandom);
        end
    endtask

    initial begin
        fail_count = 0;
        heap_size = 0;
        model_max_first = 1'b0;
        idle_enable = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_overflow(1'b1);
        test_fill_and_overflow(1'b0);
        write_mode(1'b1);
        test_random(350, 65);
        wait_drained();               // sender holds off until all results are in
        test_random(350, 40);
        write_mode(1'b0);
        // drain the heap after the mode switch so later requests start from an empty heap
        while (heap_size > 0) send_request(bhpq_pkg::REQ_POP, 32'h0);
        test_random(330, 60);
        idle_enable = 1'b0;
        test_random(250, 50);

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/bhpq_front.sv
rtl/bhpq_exec.sv
rtl/binary_heap_priority_queue.sv
bench/testbench.sv
